>>> rtl/swsfd_pkg.sv
// Shared constants and types for the single-wire sensor frame decoder.
package swsfd_pkg;

	localparam int unsigned PULSES_DEF = 41;
	localparam int unsigned IDX_W      = 6;
	localparam int unsigned WIDTH_W    = 8;
	localparam int unsigned WORD_W     = 16;
	localparam int unsigned WHOLE_W    = 8;
	localparam int unsigned CFG_IDX_W  = 2;

	// frame positions
	localparam logic [IDX_W-1:0] HUM_FIRST = 6'd1;
	localparam logic [IDX_W-1:0] HUM_LAST  = 6'd16;
	localparam logic [IDX_W-1:0] TEMP_LAST = 6'd32;

	// register reset values
	localparam logic [WIDTH_W-1:0] ZERO_MIN_RST = 8'd6;
	localparam logic [WIDTH_W-1:0] ZERO_MAX_RST = 8'd14;
	localparam logic [WIDTH_W-1:0] ONE_MIN_RST  = 8'd24;
	localparam logic [WIDTH_W-1:0] ONE_MAX_RST  = 8'd30;

	// x / 10 == (x * 52429) >> 19, exact for every 16-bit x
	localparam logic [WORD_W-1:0] DIV10_MUL   = 16'd52429;
	localparam int unsigned       DIV10_SHIFT = 19;
	localparam logic [WORD_W-1:0] TEN         = 16'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ZERO_MIN = 2'd0,
		CFG_ZERO_MAX = 2'd1,
		CFG_ONE_MIN  = 2'd2,
		CFG_ONE_MAX  = 2'd3
	} cfg_reg_t;

endpackage

>>> rtl/single_wire_sensor_frame_decoder_unit.sv
// Frame decoder: pulse widths in, humidity and temperature words out.
// Throughput: one pulse item per cycle while the result side does not stall.
// The last pulse of a frame passes the input register, then the frame-words register,
// then the divide-by-ten output register, before the frame's result is presented.
// Reset clears the pulse counter, assembly words, valids and restores window defaults.
// Configuration writes are always ready and take effect on the next pulse decoded.
module single_wire_sensor_frame_decoder_unit #(
	parameter int unsigned PULSES_PER_FRAME = swsfd_pkg::PULSES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pulse_valid,
	output logic                               pulse_stall,
	input  logic [swsfd_pkg::WIDTH_W-1:0]      pulse_width,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [swsfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [swsfd_pkg::WIDTH_W-1:0]      cfg_data,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [swsfd_pkg::WORD_W-1:0]       humidity_raw,
	output logic [swsfd_pkg::WORD_W-1:0]       temperature_raw,
	output logic [swsfd_pkg::WHOLE_W-1:0]      humidity_whole,
	output logic [swsfd_pkg::WHOLE_W-1:0]      temperature_whole
);
	import swsfd_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PULSES_PER_FRAME - 1);

	logic [WIDTH_W-1:0] zero_min_q, zero_max_q, one_min_q, one_max_q;
	logic [IDX_W-1:0]   idx_q;
	logic [WORD_W-1:0]  hum_q, temp_q;

	logic               valid_s1;
	logic [WIDTH_W-1:0] width_s1;
	logic               valid_s2;
	logic [WORD_W-1:0]  hum_s2, temp_s2;

	logic               res_go, s2_go, last, s1_done, accept;
	logic               is_zero, is_one, hit, hum_sel, temp_sel;
	logic [3:0]         hum_pos, temp_pos;
	logic [WORD_W-1:0]  hum_d, temp_d;
	logic [2*WORD_W-1:0] hum_prod, temp_prod;

	assign cfg_ready = 1'b1;

	// flow control
	assign res_go      = !result_valid || !result_stall;
	assign s2_go       = !valid_s2 || res_go;
	assign last        = idx_q >= LAST_IDX;
	assign s1_done     = valid_s1 && (!last || s2_go);
	assign pulse_stall = valid_s1 && !s1_done;
	assign accept      = pulse_valid && !pulse_stall;

	// bit decode; the zero window wins where both match
	assign is_zero  = (width_s1 > zero_min_q) && (width_s1 < zero_max_q);
	assign is_one   = (width_s1 > one_min_q) && (width_s1 < one_max_q);
	assign hit      = is_zero || is_one;
	assign hum_sel  = (idx_q >= HUM_FIRST) && (idx_q <= HUM_LAST);
	assign temp_sel = (idx_q > HUM_LAST) && (idx_q <= TEMP_LAST);
	assign hum_pos  = 4'(HUM_LAST - idx_q);
	assign temp_pos = 4'(TEMP_LAST - idx_q);

	always_comb begin
		hum_d  = hum_q;
		temp_d = temp_q;
		if (hit && hum_sel) begin
			hum_d[hum_pos] = !is_zero;
		end
		if (hit && temp_sel) begin
			temp_d[temp_pos] = !is_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_min_q <= ZERO_MIN_RST;
			zero_max_q <= ZERO_MAX_RST;
			one_min_q  <= ONE_MIN_RST;
			one_max_q  <= ONE_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ZERO_MIN: zero_min_q <= cfg_data;
				CFG_ZERO_MAX: zero_max_q <= cfg_data;
				CFG_ONE_MIN:  one_min_q  <= cfg_data;
				CFG_ONE_MAX:  one_max_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			width_s1 <= pulse_width;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			hum_q  <= '0;
			temp_q <= '0;
		end else if (s1_done) begin
			idx_q  <= last ? '0 : idx_q + 1'b1;
			hum_q  <= hum_d;
			temp_q <= temp_d;
		end
	end

	// completed frame words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_go) begin
			valid_s2 <= s1_done && last;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done && last) begin
			hum_s2  <= hum_d;
			temp_s2 <= temp_d;
		end
	end

	// divide by ten through the reciprocal
	assign hum_prod  = (2*WORD_W)'(hum_s2) * (2*WORD_W)'(DIV10_MUL);
	assign temp_prod = (2*WORD_W)'(temp_s2) * (2*WORD_W)'(DIV10_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (res_go) begin
			result_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (res_go && valid_s2) begin
			humidity_raw      <= hum_s2;
			temperature_raw   <= temp_s2;
			humidity_whole    <= hum_prod[DIV10_SHIFT +: WHOLE_W];
			temperature_whole <= temp_prod[DIV10_SHIFT +: WHOLE_W];
		end
	end

endmodule

>>> rtl/swsfd_checker.sv
// Port-level checks for the frame decoder, bound to the top level.
module swsfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [15:0] humidity_raw,
	input logic [15:0] temperature_raw,
	input logic [7:0]  humidity_whole,
	input logic [7:0]  temperature_whole
);
	import swsfd_pkg::*;

	logic [WORD_W-1:0] hum_div, temp_div;

	assign hum_div  = humidity_raw / TEN;
	assign temp_div = temperature_raw / TEN;

	a_hum_whole: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> humidity_whole == hum_div[WHOLE_W-1:0])
		else $error("humidity_whole does not match humidity_raw / 10");

	a_temp_whole: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> temperature_whole == temp_div[WHOLE_W-1:0])
		else $error("temperature_whole does not match temperature_raw / 10");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(humidity_raw) && $stable(temperature_raw))
		else $error("stalled result item changed");

endmodule

bind single_wire_sensor_frame_decoder_unit swsfd_checker u_swsfd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.result_valid      (result_valid),
	.result_stall      (result_stall),
	.humidity_raw      (humidity_raw),
	.temperature_raw   (temperature_raw),
	.humidity_whole    (humidity_whole),
	.temperature_whole (temperature_whole)
);

>>> test/single_wire_sensor_frame_decoder_unit_test.sv
// Self-checking testbench for the single-wire sensor frame decoder.
module single_wire_sensor_frame_decoder_unit_test;
	import swsfd_pkg::*;

	localparam int unsigned FRAME_LEN  = PULSES_DEF;
	localparam int unsigned SETTLE_CYC = 8;
	localparam int unsigned DRAIN_CYC  = 5000;
	localparam int unsigned PHASES     = 10;
	localparam int unsigned PHASE_LEN  = 170;

	typedef struct packed {
		logic [WORD_W-1:0]  humidity_raw;
		logic [WORD_W-1:0]  temperature_raw;
		logic [WHOLE_W-1:0] humidity_whole;
		logic [WHOLE_W-1:0] temperature_whole;
	} reading_t;

	// Tracks frame position and assembly words, queues the expected readings.
	class frame_scoreboard;
		logic [WIDTH_W-1:0] zero_lo, zero_hi, one_lo, one_hi;
		logic [IDX_W-1:0]   pos;
		logic [WORD_W-1:0]  hum_word, temp_word;
		reading_t           due[$];
		int unsigned        errors;

		function new();
			zero_lo   = ZERO_MIN_RST;
			zero_hi   = ZERO_MAX_RST;
			one_lo    = ONE_MIN_RST;
			one_hi    = ONE_MAX_RST;
			pos       = '0;
			hum_word  = '0;
			temp_word = '0;
			errors    = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [WIDTH_W-1:0] v);
			case (idx)
				CFG_ZERO_MIN: zero_lo = v;
				CFG_ZERO_MAX: zero_hi = v;
				CFG_ONE_MIN:  one_lo  = v;
				CFG_ONE_MAX:  one_hi  = v;
				default: ;
			endcase
		endfunction

		// zero window is tested first, so it wins where the two overlap
		function logic [WORD_W-1:0] decode_bit(logic [WORD_W-1:0] word, int unsigned bitpos,
				logic [WIDTH_W-1:0] w);
			logic [WORD_W-1:0] res;
			res = word;
			if (w > zero_lo && w < zero_hi)
				res[bitpos] = 1'b0;
			else if (w > one_lo && w < one_hi)
				res[bitpos] = 1'b1;
			return res;
		endfunction

		function void note_pulse(logic [WIDTH_W-1:0] w);
			int unsigned p;
			reading_t r;
			logic [WORD_W-1:0] hq, tq;
			p = pos;
			if (p >= 1 && p <= 16)
				hum_word = decode_bit(hum_word, 16 - p, w);
			else if (p >= 17 && p <= 32)
				temp_word = decode_bit(temp_word, 32 - p, w);
			if (p + 1 >= FRAME_LEN) begin
				pos = '0;
				hq = hum_word / 16'd10;
				tq = temp_word / 16'd10;
				r.humidity_raw      = hum_word;
				r.temperature_raw   = temp_word;
				r.humidity_whole    = hq[WHOLE_W-1:0];
				r.temperature_whole = tq[WHOLE_W-1:0];
				due.push_back(r);
			end else begin
				pos = IDX_W'(p + 1);
			end
		endfunction

		function void check_result(reading_t got);
			reading_t exp_r;
			if (due.size() == 0) begin
				$error("unexpected reading: humidity_raw %0d temperature_raw %0d",
					got.humidity_raw, got.temperature_raw);
				errors++;
				return;
			end
			exp_r = due.pop_front();
			if (got.humidity_raw !== exp_r.humidity_raw) begin
				$error("humidity_raw: expected %0d, got %0d",
					exp_r.humidity_raw, got.humidity_raw);
				errors++;
			end
			if (got.temperature_raw !== exp_r.temperature_raw) begin
				$error("temperature_raw: expected %0d, got %0d",
					exp_r.temperature_raw, got.temperature_raw);
				errors++;
			end
			if (got.humidity_whole !== exp_r.humidity_whole) begin
				$error("humidity_whole: expected %0d, got %0d",
					exp_r.humidity_whole, got.humidity_whole);
				errors++;
			end
			if (got.temperature_whole !== exp_r.temperature_whole) begin
				$error("temperature_whole: expected %0d, got %0d",
					exp_r.temperature_whole, got.temperature_whole);
				errors++;
			end
		endfunction
	endclass

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 pulse_valid  = 1'b0;
	logic                 pulse_stall;
	logic [WIDTH_W-1:0]   pulse_width  = '0;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [WIDTH_W-1:0]   cfg_data     = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [WORD_W-1:0]    humidity_raw;
	logic [WORD_W-1:0]    temperature_raw;
	logic [WHOLE_W-1:0]   humidity_whole;
	logic [WHOLE_W-1:0]   temperature_whole;

	frame_scoreboard sb = new();

	single_wire_sensor_frame_decoder_unit #(
		.PULSES_PER_FRAME(FRAME_LEN)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.pulse_valid      (pulse_valid),
		.pulse_stall      (pulse_stall),
		.pulse_width      (pulse_width),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.humidity_raw     (humidity_raw),
		.temperature_raw  (temperature_raw),
		.humidity_whole   (humidity_whole),
		.temperature_whole(temperature_whole)
	);

	always #2 clk = ~clk;

	// receiver stall pattern: mode is drawn at random from four patterns
	always @(posedge clk) begin
		static int unsigned cyc = 0;
		static int unsigned mode = 0;
		logic s;
		if (cyc % 150 == 0)
			mode = $urandom_range(0, 3);
		case (mode)
			1: s = 1'($urandom_range(0, 1));
			2: s = (cyc % 4 == 0);
			3: s = (cyc % 32) < 20;
			default: s = 1'b0;
		endcase
		result_stall <= s;
		cyc++;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result('{humidity_raw, temperature_raw, humidity_whole, temperature_whole});
	end

	task automatic send_pulse(input logic [WIDTH_W-1:0] w);
		pulse_valid <= 1'b1;
		pulse_width <= w;
		do @(posedge clk); while (pulse_stall);
		sb.note_pulse(w);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [WIDTH_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, v);
	endtask

	task automatic program_windows(input logic [WIDTH_W-1:0] zlo, input logic [WIDTH_W-1:0] zhi,
			input logic [WIDTH_W-1:0] olo, input logic [WIDTH_W-1:0] ohi);
		write_reg(CFG_ZERO_MIN, zlo);
		write_reg(CFG_ZERO_MAX, zhi);
		write_reg(CFG_ONE_MIN, olo);
		write_reg(CFG_ONE_MAX, ohi);
		cfg_valid <= 1'b0;
	endtask

	// wait for every reading due, then let any pulse still in the pipe finish
	task automatic settle();
		int unsigned n;
		pulse_valid <= 1'b0;
		n = 0;
		while (sb.due.size() != 0 && n < DRAIN_CYC) begin
			@(posedge clk);
			n++;
		end
		if (sb.due.size() != 0) begin
			$error("%0d readings never arrived", sb.due.size());
			sb.errors++;
			sb.due.delete();
		end
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// mostly widths inside one of the windows, the rest anywhere
	function automatic logic [WIDTH_W-1:0] pick_width();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45 && int'(sb.zero_hi) > int'(sb.zero_lo) + 1)
			return WIDTH_W'($urandom_range(sb.zero_lo + 1, sb.zero_hi - 1));
		if (r < 90 && int'(sb.one_hi) > int'(sb.one_lo) + 1)
			return WIDTH_W'($urandom_range(sb.one_lo + 1, sb.one_hi - 1));
		return WIDTH_W'($urandom_range(0, 255));
	endfunction

	task automatic run_pulses(input int unsigned n, input bit steady);
		int unsigned burst;
		int unsigned gap;
		burst = 0;
		repeat (n) begin
			if (!steady && burst == 0) begin
				gap = $urandom_range(1, 7);
				pulse_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst = $urandom_range(1, 30);
			end
			send_pulse(pick_width());
			if (burst > 0)
				burst--;
		end
	endtask

	initial begin : stimulus
		logic [WIDTH_W-1:0] directed[20];
		int a, zhi, olo, ohi;
		directed = '{8'd0, 8'd255, 8'd6, 8'd7, 8'd13, 8'd14, 8'd24, 8'd25, 8'd29, 8'd30,
			8'd10, 8'd27, 8'd128, 8'd85, 8'd170, 8'd1, 8'd254, 8'd12, 8'd26, 8'd0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset windows: each edge of both windows and width extremes
		foreach (directed[i])
			send_pulse(directed[i]);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: program_windows(8'd0, 8'd255, 8'd0, 8'd255);       // full overlap
				1: program_windows(8'd0, 8'd0, 8'd0, 8'd0);           // both empty
				2: program_windows(8'd200, 8'd100, 8'd150, 8'd50);    // inverted
				3: program_windows(8'd0, 8'd128, 8'd127, 8'd255);
				4: program_windows(8'd255, 8'd255, 8'd255, 8'd255);
				5: program_windows(8'd100, 8'd120, 8'd10, 8'd110);    // one window overlaps the zero window
				6, 7: begin
					a   = $urandom_range(0, 100);
					zhi = a + $urandom_range(2, 50);
					olo = zhi + $urandom_range(0, 50);
					ohi = olo + $urandom_range(2, 60);
					if (ohi > 255)
						ohi = 255;
					program_windows(WIDTH_W'(a), WIDTH_W'(zhi), WIDTH_W'(olo),
						WIDTH_W'(ohi));
				end
				8: program_windows(WIDTH_W'($urandom_range(0, 255)),
					WIDTH_W'($urandom_range(0, 255)),
					WIDTH_W'($urandom_range(0, 255)),
					WIDTH_W'($urandom_range(0, 255)));
				default: program_windows(ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST);
			endcase
			run_pulses(PHASE_LEN, ph % 3 == 1);
			settle();
		end

		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#800000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
